FILE: src/pbap_pkg.sv
// Shared types and constants of the panel brightness and ACL policy block.
package pbap_pkg;

    // Input command codes.
    localparam logic CMD_BRIGHT = 1'b0;
    localparam logic CMD_ACL    = 1'b1;

    // Panel variants.
    localparam logic [1:0] PT_OTHER  = 2'd0;
    localparam logic [1:0] PT_M2     = 2'd1;
    localparam logic [1:0] PT_SM2_A1 = 2'd2;
    localparam logic [1:0] PT_SM2_A2 = 2'd3;

    // Table kinds. The kind code doubles as the bit position in the result mask.
    localparam logic [2:0] KIND_ELVSS    = 3'd0;
    localparam logic [2:0] KIND_ACL_INIT = 3'd1;
    localparam logic [2:0] KIND_ACL_CUT  = 3'd2;
    localparam logic [2:0] KIND_GAMMA    = 3'd3;
    localparam logic [2:0] KIND_GUPD     = 3'd4;
    localparam int unsigned NUM_KINDS    = 5;

    // Configuration register indexes.
    localparam logic REG_PANEL_TYPE    = 1'b0;
    localparam logic REG_PANEL_ENABLED = 1'b1;

    // Gamma mapping: q = floor(230*b/225) computed as (b * GAMMA_RECIP) >> GAMMA_SHIFT,
    // then gamma = floor((q - GAMMA_OFS) / 10) as ((q - GAMMA_OFS) * DIV10_RECIP) >> 11.
    localparam logic [7:0]  BRIGHT_MIN   = 8'd30;
    localparam logic [25:0] GAMMA_RECIP  = 26'd34300130;
    localparam int unsigned GAMMA_SHIFT  = 25;
    localparam logic [8:0]  GAMMA_OFS    = 9'd15;
    localparam logic [7:0]  DIV10_RECIP  = 8'd205;
    localparam int unsigned DIV10_SHIFT  = 11;

    localparam logic [4:0] ACL_INIT_WAIT = 5'd20;

    typedef struct packed {
        logic       cmd;
        logic [7:0] value;
    } t_in_item;

    typedef struct packed {
        logic [2:0] table_kind;
        logic [4:0] table_index;
        logic [4:0] wait_ms;
        logic [5:0] acl_percent;
        logic       last;
    } t_out_item;

    // A classified request waiting for the sequencer.
    typedef struct packed {
        logic       is_acl;
        logic       acl_on;
        logic [4:0] gamma;
    } t_job;

endpackage

FILE: src/panel_brightness_acl_policy.sv
// Top level of the panel brightness and ACL policy block.
//
//  Port group        Direction  Handshake               Payload
//  request in        in         i_in_valid / o_in_stall  i_in_data (cmd, value)
//  selection out     out        o_out_valid / i_out_stall o_out_data (kind, index,
//                                                         wait, percent, last)
//  configuration     in/out     psel, penable, pready    paddr, pwdata, prdata
//
// A request is registered in the front end, where its gamma level is finished,
// and then queued; the sequencer loads it and sends its selections, zero to
// five, one per cycle while the output is not stalled, and loads the next
// request only once the last one has been sent. On an idle path the request
// passes the front register, the queue and the load before o_out_valid rises.
// Requests that the panel state rules out are dropped in the front end at
// acceptance; an ACL request that leaves the cutoff alone still spends its
// load cycle in the sequencer and sends nothing.
// Reset is synchronous and active low; it restores the panel type, enable,
// gamma level, ACL enable and cutoff and empties the queue at once.
// A stall on the output holds the selection register and, once the queue has
// filled, backs up to o_in_stall; the two sides otherwise run independently.
module panel_brightness_acl_policy import pbap_pkg::*; #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Request channel.
    input  logic        i_in_valid,
    input  t_in_item    i_in_data,
    output logic        o_in_stall,
    // Selection channel.
    output logic        o_out_valid,
    output t_out_item   o_out_data,
    input  logic        i_out_stall,
    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [1:0] r_panel_type;
    logic       r_panel_enabled;
    logic       cfg_wr;
    logic       q_push;
    logic       q_pop;
    logic       q_full;
    logic       q_empty;
    t_job       push_job;
    t_job       head_job;

    // Registers sit at byte addresses 0 and 4; bit 2 selects between them.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_panel_type    <= PT_SM2_A2;
            r_panel_enabled <= 1'b1;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                REG_PANEL_TYPE:    r_panel_type    <= pwdata[1:0];
                REG_PANEL_ENABLED: r_panel_enabled <= pwdata[0];
                default:           r_panel_type    <= r_panel_type;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_PANEL_TYPE:    prdata = 32'(r_panel_type);
            REG_PANEL_ENABLED: prdata = 32'(r_panel_enabled);
            default:           prdata = 32'd0;
        endcase
    end

    // The front end owns the ACL enable so it can drop repeated requests early.
    pbap_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_panel_enabled (r_panel_enabled),
        .i_in_valid      (i_in_valid),
        .i_in_data       (i_in_data),
        .o_in_stall      (o_in_stall),
        .i_q_full        (q_full),
        .o_push          (q_push),
        .o_job           (push_job)
    );

    pbap_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (push_job),
        .i_pop   (q_pop),
        .o_data  (head_job),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    // The sequencer owns the gamma level and cutoff, which it updates as each
    // request is loaded, so requests see each other's effects in order.
    pbap_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_panel_type (r_panel_type),
        .i_job        (head_job),
        .i_q_empty    (q_empty),
        .o_pop        (q_pop),
        .o_out_valid  (o_out_valid),
        .o_out_data   (o_out_data),
        .i_out_stall  (i_out_stall)
    );

endmodule

FILE: src/pbap_front.sv
// Front end: accepts requests, filters them and computes the gamma level.
module pbap_front import pbap_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_panel_enabled,
    input  logic     i_in_valid,
    input  t_in_item i_in_data,
    output logic     o_in_stall,
    input  logic     i_q_full,
    output logic     o_push,
    output t_job     o_job
);

    logic        r_s1_vld;
    logic        r_acl_on;
    logic        r_is_acl;
    logic        r_job_acl;
    logic        r_low;
    logic [8:0]  r_q;

    logic        accept;
    logic        is_bri;
    logic        is_acl;
    logic        n_acl_on;
    logic [33:0] prod;
    logic [8:0]  y9;
    logic [15:0] ym;

    assign o_in_stall = r_s1_vld && i_q_full;
    assign accept     = i_in_valid && !o_in_stall;
    assign o_push     = r_s1_vld && !i_q_full;

    assign is_bri = (i_in_data.cmd == CMD_BRIGHT) && i_panel_enabled;
    assign is_acl = (i_in_data.cmd == CMD_ACL) && i_panel_enabled
                    && (i_in_data.value[7:1] == 7'd0)
                    && (i_in_data.value[0] != r_acl_on);
    assign n_acl_on = is_acl ? i_in_data.value[0] : r_acl_on;

    assign prod = 34'(i_in_data.value) * 34'(GAMMA_RECIP);

    // Second step of the mapping runs on the registered quotient.
    assign y9 = r_q - GAMMA_OFS;
    assign ym = 16'(y9[7:0]) * 16'(DIV10_RECIP);

    always_comb begin
        o_job.is_acl = r_is_acl;
        o_job.acl_on = r_job_acl;
        o_job.gamma  = r_low ? 5'd0 : ym[DIV10_SHIFT +: 5];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_acl_on <= 1'b0;
        end else begin
            if (accept) begin
                r_s1_vld <= is_bri || is_acl;
                r_acl_on <= n_acl_on;
            end else if (o_push) begin
                r_s1_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_is_acl  <= is_acl;
            r_job_acl <= n_acl_on;
            r_low     <= i_in_data.value < BRIGHT_MIN;
            r_q       <= prod[GAMMA_SHIFT +: 9];
        end
    end

endmodule

FILE: src/pbap_fifo.sv
// Small register queue of classified requests between front end and sequencer.
module pbap_fifo import pbap_pkg::*; #(
    parameter int DEPTH = 4
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_data,
    input  logic i_pop,
    output t_job o_data,
    output logic o_full,
    output logic o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_job          r_mem [DEPTH];
    logic [AW-1:0] r_wr;
    logic [AW-1:0] r_rd;
    logic [CW-1:0] r_cnt;
    logic          do_push;
    logic          do_pop;

    assign o_full  = r_cnt == CW'(DEPTH);
    assign o_empty = r_cnt == '0;
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

FILE: src/pbap_back.sv
// Sequencer: turns each request into its ordered list of table selections.
module pbap_back import pbap_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic [1:0] i_panel_type,
    input  t_job      i_job,
    input  logic      i_q_empty,
    output logic      o_pop,
    output logic      o_out_valid,
    output t_out_item o_out_data,
    input  logic      i_out_stall
);

    typedef struct packed {
        logic [5:0] pct;
        logic [4:0] idx;
    } t_cut;

    function automatic t_cut cut_target(input logic [4:0] g, input logic a2);
        t_cut c;
        c = '{pct: 6'd50, idx: 5'd13};
        if (g <= 5'd1) begin
            c = '{pct: 6'd0, idx: 5'd0};
        end else if (a2) begin
            if (g <= 5'd19) begin
                c = '{pct: 6'd40, idx: 5'd1};
            end else begin
                c = '{pct: 6'd50, idx: 5'd6};
            end
        end else if (g <= 5'd12) begin
            c = '{pct: 6'd40, idx: 5'd9};
        end else if (g == 5'd13) begin
            c = '{pct: 6'd43, idx: 5'd16};
        end else if (g == 5'd14) begin
            c = '{pct: 6'd45, idx: 5'd10};
        end else if (g == 5'd15) begin
            c = '{pct: 6'd47, idx: 5'd11};
        end else if (g == 5'd16) begin
            c = '{pct: 6'd48, idx: 5'd12};
        end
        return c;
    endfunction

    // Persistent policy state.
    logic [4:0]           r_gamma;
    logic [5:0]           r_cut;
    // Current request: remaining results and their fields.
    logic [NUM_KINDS-1:0] r_mask;
    logic [4:0]           r_g;
    logic [1:0]           r_band;
    logic [4:0]           r_cidx;
    logic [5:0]           r_old;
    logic [5:0]           r_new;
    logic                 r_out_vld;
    t_out_item            r_out;

    logic                 load;
    logic                 emit;
    logic                 a2;
    logic [4:0]           g;
    t_cut                 tgt;
    logic [NUM_KINDS-1:0] n_mask;
    logic [5:0]           n_cut;
    logic [4:0]           n_cidx;
    logic [1:0]           n_band;
    logic [NUM_KINDS-1:0] sel;
    logic [2:0]           sel_kind;
    t_out_item            n_out;

    assign a2  = i_panel_type == PT_SM2_A2;
    assign g   = i_job.is_acl ? r_gamma : i_job.gamma;
    assign tgt = cut_target(g, a2);

    assign load  = (r_mask == '0) && !i_q_empty;
    assign o_pop = load;
    assign emit  = (r_mask != '0) && (!r_out_vld || !i_out_stall);

    always_comb begin
        n_mask = '0;
        n_cut  = 6'd0;
        n_cidx = 5'd0;
        if (i_job.acl_on) begin
            n_mask[KIND_ACL_INIT] = (r_cut == 6'd0) && (g >= 5'd2);
            n_mask[KIND_ACL_CUT]  = tgt.pct != r_cut;
            n_cut                 = tgt.pct;
            n_cidx                = tgt.idx;
        end else if (a2) begin
            n_mask[KIND_ACL_CUT] = r_cut != 6'd0;
        end else begin
            n_mask[KIND_ACL_CUT] = 1'b1;
        end
        if (!i_job.is_acl) begin
            n_mask[KIND_ELVSS] = (i_panel_type == PT_M2) || a2;
            n_mask[KIND_GAMMA] = 1'b1;
            n_mask[KIND_GUPD]  = !a2;
        end
    end

    always_comb begin
        if (g <= 5'd4) begin
            n_band = 2'd0;
        end else if (g <= 5'd10) begin
            n_band = 2'd1;
        end else if (g <= 5'd14) begin
            n_band = 2'd2;
        end else begin
            n_band = 2'd3;
        end
    end

    // Lowest pending result goes out first.
    always_comb begin
        sel      = '0;
        sel_kind = KIND_GUPD;
        priority if (r_mask[KIND_ELVSS]) begin
            sel_kind = KIND_ELVSS;
        end else if (r_mask[KIND_ACL_INIT]) begin
            sel_kind = KIND_ACL_INIT;
        end else if (r_mask[KIND_ACL_CUT]) begin
            sel_kind = KIND_ACL_CUT;
        end else if (r_mask[KIND_GAMMA]) begin
            sel_kind = KIND_GAMMA;
        end else begin
            sel_kind = KIND_GUPD;
        end
        sel[sel_kind] = 1'b1;
    end

    always_comb begin
        n_out.table_kind  = sel_kind;
        n_out.table_index = 5'd0;
        n_out.wait_ms     = 5'd0;
        n_out.acl_percent = r_new;
        n_out.last        = (r_mask & ~sel) == '0;
        unique case (sel_kind)
            KIND_ELVSS: begin
                n_out.table_index = 5'(r_band);
                n_out.acl_percent = r_old;
            end
            KIND_ACL_INIT: begin
                n_out.wait_ms     = ACL_INIT_WAIT;
                n_out.acl_percent = r_old;
            end
            KIND_ACL_CUT: begin
                n_out.table_index = r_cidx;
            end
            KIND_GAMMA: begin
                n_out.table_index = r_g;
            end
            default: begin
                n_out.table_index = 5'd0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gamma   <= 5'd0;
            r_cut     <= 6'd0;
            r_mask    <= '0;
            r_out_vld <= 1'b0;
        end else begin
            if (load) begin
                r_mask <= n_mask;
                r_cut  <= n_cut;
                if (!i_job.is_acl) begin
                    r_gamma <= g;
                end
            end else if (emit) begin
                r_mask <= r_mask & ~sel;
            end
            if (emit) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_g    <= g;
            r_band <= n_band;
            r_cidx <= n_cidx;
            r_old  <= r_cut;
            r_new  <= n_cut;
        end
        if (emit) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    a_cut_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cut == 6'd0 || r_cut == 6'd40 || r_cut == 6'd43 || r_cut == 6'd45
        || r_cut == 6'd47 || r_cut == 6'd48 || r_cut == 6'd50)
        else $error("ACL cutoff left the legal set");

    a_more_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && !r_out.last |-> r_mask != '0)
        else $error("result not marked last but nothing else is pending");

    a_init_from_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && r_out.table_kind == KIND_ACL_INIT |-> r_out.acl_percent == 6'd0)
        else $error("ACL init sent while a cutoff was already in force");

endmodule

FILE: sim/pbap_selection_checker.sv
`timescale 1ns / 100ps
// Selection checker: predicts the table selections of each accepted request and compares them.
module pbap_selection_checker import pbap_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  t_in_item    i_in_data,
    input  logic        i_in_stall,
    input  logic        i_out_valid,
    input  t_out_item   i_out_data,
    input  logic        i_out_stall,
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic [2:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    input  logic        i_pready,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_checked
);

    localparam int unsigned SCALE_NUM     = 230;
    localparam int unsigned SCALE_DEN     = 225;
    localparam int unsigned TENTHS_OFFSET = 20;

    logic [1:0] panel_kind;
    logic       panel_on;
    logic [7:0] bright_req;
    logic [4:0] gamma_held;
    logic       acl_en;
    logic [5:0] cutoff_pct;

    t_out_item selections_due[$];
    t_out_item step_list[$];
    int        fail_total    = 0;
    int        checked_total = 0;

    assign o_fail_count = fail_total;
    assign o_checked    = checked_total;

    function automatic logic [4:0] gamma_of(input logic [7:0] level);
        int unsigned tenths;
        if (level < BRIGHT_MIN) return 5'd0;
        tenths = (SCALE_NUM * int'(level)) / SCALE_DEN - TENTHS_OFFSET;
        return 5'((tenths + 5) / 10);
    endfunction

    function automatic logic [4:0] elvss_band(input logic [4:0] g);
        if (g <= 4) return 5'd0;
        if (g <= 10) return 5'd1;
        if (g <= 14) return 5'd2;
        return 5'd3;
    endfunction

    // The percentage reported is the one in force once the selection is sent.
    task automatic add_sel(input logic [2:0] kind, input logic [4:0] index,
                           input logic [4:0] delay_ms);
        step_list.push_back('{table_kind: kind, table_index: index, wait_ms: delay_ms,
                              acl_percent: cutoff_pct, last: 1'b0});
    endtask

    task automatic move_cutoff(input logic [5:0] pct, input logic [4:0] index);
        if (cutoff_pct != pct) begin
            cutoff_pct = pct;
            add_sel(KIND_ACL_CUT, index, 5'd0);
        end
    endtask

    task automatic acl_refresh;
        logic a2;
        a2 = (panel_kind == PT_SM2_A2);
        if (acl_en) begin
            if (cutoff_pct == 0 && gamma_held >= 2) add_sel(KIND_ACL_INIT, 5'd0, ACL_INIT_WAIT);
            if (gamma_held <= 1) begin
                move_cutoff(6'd0, 5'd0);
            end else if (a2) begin
                if (gamma_held <= 19) move_cutoff(6'd40, 5'd1);
                else move_cutoff(6'd50, 5'd6);
            end else begin
                unique case (gamma_held)
                    5'd13: move_cutoff(6'd43, 5'd16);
                    5'd14: move_cutoff(6'd45, 5'd10);
                    5'd15: move_cutoff(6'd47, 5'd11);
                    5'd16: move_cutoff(6'd48, 5'd12);
                    default: begin
                        if (gamma_held <= 12) move_cutoff(6'd40, 5'd9);
                        else move_cutoff(6'd50, 5'd13);
                    end
                endcase
            end
        end else if (a2) begin
            move_cutoff(6'd0, 5'd0);
        end else begin
            // Non-A2 panels always resend the zero cutoff when ACL is off.
            cutoff_pct = 6'd0;
            add_sel(KIND_ACL_CUT, 5'd0, 5'd0);
        end
    endtask

    task automatic brightness_refresh;
        gamma_held = gamma_of(bright_req);
        if (panel_kind == PT_M2 || panel_kind == PT_SM2_A2)
            add_sel(KIND_ELVSS, elvss_band(gamma_held), 5'd0);
        acl_refresh();
        add_sel(KIND_GAMMA, gamma_held, 5'd0);
        if (panel_kind != PT_SM2_A2) add_sel(KIND_GUPD, 5'd0, 5'd0);
    endtask

    task automatic plan_selections(input t_in_item req);
        t_out_item tail;
        step_list.delete();
        if (req.cmd == CMD_BRIGHT) begin
            bright_req = req.value;
            if (panel_on) brightness_refresh();
        end else if (panel_on && req.value <= 1 && req.value[0] != acl_en) begin
            acl_en = req.value[0];
            acl_refresh();
        end
        if (step_list.size() > 0) begin
            tail = step_list.pop_back();
            tail.last = 1'b1;
            step_list.push_back(tail);
        end
        foreach (step_list[i]) selections_due.push_back(step_list[i]);
    endtask

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            panel_kind = PT_SM2_A2;
            panel_on   = 1'b1;
            bright_req = 8'd255;
            gamma_held = 5'd0;
            acl_en     = 1'b0;
            cutoff_pct = 6'd0;
            selections_due.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (selections_due.size() == 0) begin
                    fail_total++;
                    $display("%0t: unexpected selection kind=%0d idx=%0d wait=%0d",
                             $time, i_out_data.table_kind, i_out_data.table_index,
                             i_out_data.wait_ms, " pct=%0d last=%0d",
                             i_out_data.acl_percent, i_out_data.last);
                end else begin
                    want = selections_due.pop_front();
                    checked_total++;
                    if (want !== i_out_data) begin
                        fail_total++;
                        $display("%0t: expected kind=%0d idx=%0d wait=%0d pct=%0d last=%0d,",
                                 $time, want.table_kind, want.table_index, want.wait_ms,
                                 want.acl_percent, want.last,
                                 " got kind=%0d idx=%0d wait=%0d pct=%0d last=%0d",
                                 i_out_data.table_kind, i_out_data.table_index,
                                 i_out_data.wait_ms, i_out_data.acl_percent,
                                 i_out_data.last);
                    end
                end
            end
            if (i_in_valid && !i_in_stall) plan_selections(i_in_data);
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                if (i_paddr[2] == REG_PANEL_TYPE) panel_kind = i_pwdata[1:0];
                else if (i_paddr[2] == REG_PANEL_ENABLED) panel_on = i_pwdata[0];
            end
        end
        o_pending = selections_due.size();
    end

endmodule

FILE: sim/tb.sv
`timescale 1ns / 100ps
// Testbench top: request and register stimulus for the panel brightness and ACL policy block.
module tb import pbap_pkg::*; ();

    // Cycles allowed after the last expected selection before touching the registers.
    // Requests still in flight then send nothing and leave the sequencer once they
    // are loaded, so this covers the front register, the queue and the load cycles.
    localparam int SETTLE_CYCLES = 12;
    localparam int PHASE_ITEMS   = 20;

    logic        i_clk    = 1'b0;
    logic        i_rst_n  = 1'b0;
    logic        in_valid = 1'b0;
    t_in_item    in_data  = '0;
    logic        in_stall;
    logic        out_valid;
    t_out_item   out_data;
    logic        out_stall = 1'b0;
    logic        psel      = 1'b0;
    logic        penable   = 1'b0;
    logic        pwrite    = 1'b0;
    logic [2:0]  paddr     = '0;
    logic [31:0] pwdata    = '0;
    logic [31:0] prdata;
    logic        pready;

    int fail_count;
    int pending;
    int checked;
    int sent_count     = 0;
    int settings_count = 0;
    int burst_left     = 0;

    // The clock runs with a 4 ns period.
    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    panel_brightness_acl_policy u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_valid),
        .i_in_data  (in_data),
        .o_in_stall (in_stall),
        .o_out_valid(out_valid),
        .o_out_data (out_data),
        .i_out_stall(out_stall),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    // The checker follows both channels and the register port on its own.
    pbap_selection_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .i_in_data   (in_data),
        .i_in_stall  (in_stall),
        .i_out_valid (out_valid),
        .i_out_data  (out_data),
        .i_out_stall (out_stall),
        .i_psel      (psel),
        .i_penable   (penable),
        .i_pwrite    (pwrite),
        .i_paddr     (paddr),
        .i_pwdata    (pwdata),
        .i_pready    (pready),
        .o_fail_count(fail_count),
        .o_pending   (pending),
        .o_checked   (checked)
    );

    // Offers one request and holds it until it is taken. All tasks start and end at a
    // falling edge. After each item the sender either keeps its burst going or drops
    // valid for a random number of cycles, so gaps land on every phase of the sequencer.
    task automatic send_request(input logic cmd, input logic [7:0] level);
        int gap;
        in_valid <= 1'b1;
        in_data  <= '{cmd: cmd, value: level};
        do @(posedge i_clk); while (in_stall);
        sent_count++;
        @(negedge i_clk);
        if (burst_left == 0) begin
            gap = $urandom_range(1, 7);
            in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
            // Every fifth burst or so is a long one with no idle cycles at all.
            burst_left = ($urandom_range(0, 4) == 0) ? 30 : $urandom_range(0, 6);
        end else begin
            burst_left--;
        end
    endtask

    // Holds the sender back until every predicted selection has been seen, then lets
    // the block settle so that a register write lands while it is idle.
    task automatic drain_and_settle;
        in_valid <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Register write with a setup and an access phase. Bits above the register width
    // carry random junk, since the block keeps only the low bits.
    task automatic reg_write(input logic idx, input logic [31:0] data);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic apply_setting(input logic [1:0] kind, input logic enabled);
        drain_and_settle();
        reg_write(REG_PANEL_TYPE, ($urandom() & ~32'h3) | 32'(kind));
        reg_write(REG_PANEL_ENABLED, ($urandom() & ~32'h1) | 32'(enabled));
        settings_count++;
    endtask

    // Random request mix: mostly brightness (with extra weight on the dark end where
    // the gamma and ELVSS thresholds sit), many ACL toggles, and some invalid ACL values.
    task automatic send_random_request;
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 50) send_request(CMD_BRIGHT, 8'($urandom_range(0, 255)));
        else if (pick < 62) send_request(CMD_BRIGHT, 8'($urandom_range(0, 45)));
        else if (pick < 90) send_request(CMD_ACL, 8'($urandom_range(0, 1)));
        else send_request(CMD_ACL, 8'($urandom_range(0, 255)));
    endtask

    // The receiver changes its stall habit from one span of random length to the next:
    // never stalling, stalling now and then, stalling most of the time, or toggling every cycle.
    initial begin
        int mode;
        int span;
        forever begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(20, 120);
            repeat (span) begin
                @(negedge i_clk);
                case (mode)
                    0: out_stall <= 1'b0;
                    1: out_stall <= ($urandom_range(0, 3) == 0);
                    2: out_stall <= ($urandom_range(0, 3) != 0);
                    default: out_stall <= ~out_stall;
                endcase
            end
        end
    end

    // Stimulus and verdict.
    initial begin
        logic [1:0] kinds[6];
        logic       enables[6];
        int         items;
        kinds   = '{PT_OTHER, PT_M2, PT_SM2_A1, PT_SM2_A2, PT_M2, PT_SM2_A2};
        enables = '{1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1};

        // Synchronous reset, released at a falling edge.
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed part on the reset setting (A2 panel, enabled): the dark cutoff
        // below 30, the first nonzero gamma, ACL on at low and high gamma with the
        // A2 step between 19 and 20, a repeated and an invalid ACL value, ACL off.
        send_request(CMD_BRIGHT, 8'd0);
        send_request(CMD_BRIGHT, 8'd29);
        send_request(CMD_BRIGHT, 8'd30);
        send_request(CMD_ACL, 8'd1);
        send_request(CMD_BRIGHT, 8'd35);
        send_request(CMD_BRIGHT, 8'd201);
        send_request(CMD_BRIGHT, 8'd211);
        send_request(CMD_BRIGHT, 8'd255);
        send_request(CMD_ACL, 8'd1);
        send_request(CMD_ACL, 8'd2);
        send_request(CMD_ACL, 8'd0);
        send_request(CMD_BRIGHT, 8'd142);

        // Other panel type: each of the fine cutoff steps from gamma 13 to 17,
        // then ACL off, which always resends the zero cutoff on this type.
        apply_setting(PT_OTHER, 1'b1);
        send_request(CMD_ACL, 8'd1);
        send_request(CMD_BRIGHT, 8'd142);
        send_request(CMD_BRIGHT, 8'd152);
        send_request(CMD_BRIGHT, 8'd162);
        send_request(CMD_BRIGHT, 8'd172);
        send_request(CMD_BRIGHT, 8'd182);
        send_request(CMD_BRIGHT, 8'd30);
        send_request(CMD_ACL, 8'd0);
        send_request(CMD_BRIGHT, 8'd0);

        // A disabled panel drops brightness and ACL requests; re-enabling it
        // must not replay a dropped request.
        apply_setting(PT_OTHER, 1'b0);
        send_request(CMD_BRIGHT, 8'd100);
        send_request(CMD_ACL, 8'd1);
        apply_setting(PT_OTHER, 1'b1);
        send_request(CMD_ACL, 8'd1);

        // Random part, one phase per setting. Each phase begins with the sender held
        // until every outstanding selection has come back.
        foreach (kinds[p]) begin
            apply_setting(kinds[p], enables[p]);
            items = enables[p] ? PHASE_ITEMS : PHASE_ITEMS / 2;
            repeat (items) send_random_request();
        end

        drain_and_settle();
        $display("Sent %0d requests over %0d register settings; %0d selections compared.",
                 sent_count, settings_count, checked);
        if (fail_count == 0 && pending == 0) begin
            $display("panel_brightness_acl_policy: match");
        end else begin
            $display("panel_brightness_acl_policy: mismatch");
        end
        $finish;
    end

    // Watchdog, far beyond the slowest correct run.
    initial begin
        #2_000_000;
        $display("Timed out with %0d selections still outstanding.", pending);
        $display("panel_brightness_acl_policy: mismatch");
        $finish;
    end

endmodule
